// ----- rtl/usb_config_descriptor_parser_unit_defines.svh -----
// Assertion macros used by the checker file of the descriptor parser.
`ifndef USB_CONFIG_DESCRIPTOR_PARSER_UNIT_DEFINES_SVH
`define USB_CONFIG_DESCRIPTOR_PARSER_UNIT_DEFINES_SVH

// Assert a property on a given clock, disabled while the reset is asserted.
`define UCDP_ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("descriptor parser check failed");

// Assert a property on the block clock and reset.
`define UCDP_ASSERT(lbl, prop) `UCDP_ASSERT_CLK(lbl, aclk, aresetn, prop)

`endif

// ----- rtl/ucdp_pkg.sv -----
// Types and constants of the USB configuration descriptor parser.
`timescale 1ns / 1ps
package ucdp_pkg;

    localparam logic [7:0] KIND_INTERFACE = 8'd4;
    localparam logic [7:0] KIND_ENDPOINT  = 8'd5;
    localparam logic [1:0] XFER_INTERRUPT = 2'd3;
    localparam logic [7:0] IF_MIN_LEN     = 8'd9;
    localparam logic [7:0] EP_MIN_LEN     = 8'd7;
    localparam logic [7:0] DESC_MIN_LEN   = 8'd2;

    localparam logic [1:0] STATUS_COMPLETE  = 2'd0;
    localparam logic [1:0] STATUS_STOPPED   = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    localparam logic [1:0] CFG_DEVICE_CLASS    = 2'd0;
    localparam logic [1:0] CFG_DEVICE_SUBCLASS = 2'd1;
    localparam logic [1:0] CFG_DEVICE_PROTOCOL = 2'd2;

    localparam int TDATA_OUT_W = 56;

    // One byte request handed to the parser core.
    typedef struct packed {
        logic       fire;
        logic       last;
        logic [7:0] data;
    } step_t;

    // Starting codes from the configuration registers.
    typedef struct packed {
        logic [7:0] protocol_code;
        logic [7:0] sub_class;
        logic [7:0] base_class;
    } codes_t;

    typedef struct packed {
        logic [1:0]  parse_status;
        logic        endpoint_found;
        logic [15:0] endpoint_max_packet;
        logic [7:0]  endpoint_interval;
        logic [3:0]  endpoint_number;
        logic [7:0]  protocol_code;
        logic [7:0]  sub_class;
        logic [7:0]  base_class;
    } result_t;

endpackage

// ----- rtl/ucdp_core.sv -----
// Parser state and per-byte next-state logic of the descriptor parser.
`timescale 1ns / 1ps
module ucdp_core #(
    parameter int MAX_BYTES = 255,
    parameter int CNT_W     = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ucdp_pkg::step_t  step,
    input  ucdp_pkg::codes_t cfg_codes,
    output ucdp_pkg::result_t res
);
    import ucdp_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       pos_reg, pos_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       kind_reg, kind_next;
    logic [4:0][7:0]  fb_reg, fb_next;
    logic             stop_reg, stop_next;
    codes_t           codes_reg, codes_next;
    logic [3:0]       ep_num_reg, ep_num_next;
    logic [7:0]       ep_int_reg, ep_int_next;
    logic [15:0]      ep_mps_reg, ep_mps_next;
    logic             ep_ok_reg, ep_ok_next;

    logic       first;
    logic [7:0] pos_b;
    logic       stop_b;
    logic       take;
    logic       fin;
    logic [2:0] fb_idx;

    always_comb begin
        first  = (count_reg == '0);
        pos_b  = first ? 8'd0 : pos_reg;
        stop_b = first ? 1'b0 : stop_reg;
        take   = (count_reg < CNT_W'(MAX_BYTES)) && !stop_b;
        fb_idx = 3'd0;
        fin    = 1'b0;

        len_next  = len_reg;
        kind_next = kind_reg;
        fb_next   = fb_reg;
        pos_next  = pos_b;
        stop_next = stop_b;

        // stream start loads the codes and clears the endpoint record
        codes_next  = first ? cfg_codes : codes_reg;
        ep_num_next = first ? 4'd0 : ep_num_reg;
        ep_int_next = first ? 8'd0 : ep_int_reg;
        ep_mps_next = first ? 16'd0 : ep_mps_reg;
        ep_ok_next  = first ? 1'b0 : ep_ok_reg;

        if (take) begin
            if (pos_b == 8'd0) begin
                len_next = step.data;
                pos_next = 8'd1;
            end else if (pos_b == 8'd1 && len_reg < DESC_MIN_LEN) begin
                kind_next = step.data;
                stop_next = 1'b1;
            end else begin
                if (pos_b == 8'd1) begin
                    kind_next = step.data;
                end else if (kind_reg == KIND_INTERFACE && (pos_b inside {[8'd5:8'd7]})) begin
                    fb_idx = pos_b[2:0] - 3'd5;
                    fb_next[fb_idx] = step.data;
                end else if (kind_reg == KIND_ENDPOINT && pos_b <= 8'd6) begin
                    fb_idx = pos_b[2:0] - 3'd2;
                    fb_next[fb_idx] = step.data;
                end
                if (({1'b0, pos_b} + 9'd1) == {1'b0, len_reg}) begin
                    fin      = 1'b1;
                    pos_next = 8'd0;
                end else begin
                    pos_next = pos_b + 8'd1;
                end
            end
        end

        // act on a descriptor once its last byte is in
        if (fin) begin
            if (kind_next == KIND_INTERFACE && len_next >= IF_MIN_LEN &&
                codes_next.base_class == 8'd0) begin
                codes_next.base_class    = fb_next[0];
                codes_next.sub_class     = fb_next[1];
                codes_next.protocol_code = fb_next[2];
            end
            if (kind_next == KIND_ENDPOINT && len_next >= EP_MIN_LEN &&
                fb_next[1][1:0] == XFER_INTERRUPT && fb_next[0][7]) begin
                ep_num_next = fb_next[0][3:0];
                ep_mps_next = {fb_next[3], fb_next[2]};
                ep_int_next = fb_next[4];
                ep_ok_next  = 1'b1;
            end
        end

        res.base_class          = codes_next.base_class;
        res.sub_class           = codes_next.sub_class;
        res.protocol_code       = codes_next.protocol_code;
        res.endpoint_number     = ep_num_next;
        res.endpoint_interval   = ep_int_next;
        res.endpoint_max_packet = ep_mps_next;
        res.endpoint_found      = ep_ok_next;
        if (stop_next) begin
            res.parse_status = STATUS_STOPPED;
        end else if (pos_next != 8'd0) begin
            res.parse_status = STATUS_TRUNCATED;
        end else begin
            res.parse_status = STATUS_COMPLETE;
        end

        if (step.last) begin
            count_next = '0;
        end else if (count_reg < CNT_W'(MAX_BYTES)) begin
            count_next = count_reg + CNT_W'(1);
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            pos_reg    <= 8'd0;
            stop_reg   <= 1'b0;
            len_reg    <= 8'd0;
            kind_reg   <= 8'd0;
            fb_reg     <= '0;
            codes_reg  <= '0;
            ep_num_reg <= 4'd0;
            ep_int_reg <= 8'd0;
            ep_mps_reg <= 16'd0;
            ep_ok_reg  <= 1'b0;
        end else if (step.fire) begin
            count_reg  <= count_next;
            // end of stream clears position and stop flag
            pos_reg    <= step.last ? 8'd0 : pos_next;
            stop_reg   <= step.last ? 1'b0 : stop_next;
            len_reg    <= len_next;
            kind_reg   <= kind_next;
            fb_reg     <= fb_next;
            codes_reg  <= codes_next;
            ep_num_reg <= ep_num_next;
            ep_int_reg <= ep_int_next;
            ep_mps_reg <= ep_mps_next;
            ep_ok_reg  <= ep_ok_next;
        end
    end

endmodule

// ----- rtl/usb_config_descriptor_parser_unit.sv -----
// Top level of the USB configuration descriptor parser.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  s_      | in        | s_tvalid/s_tready  | s_tdata data_byte, s_tlast last_byte
//  m_      | out       | m_tvalid/m_tready  | m_tdata result, one per stream
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One byte a cycle unless a held result stalls the last byte: a byte waits in the
// input register, then the parser core updates its state and, on the last byte,
// the result register, whose valid flag drives m_tvalid.
// A result waiting in the output register stalls only a following last byte.
// Reset (aresetn low, synchronous) clears all state but the input data and result
// registers; configuration is taken at the first byte of each stream.
`timescale 1ns / 1ps
module usb_config_descriptor_parser_unit #(
    parameter int MAX_BYTES = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] base class, [15:8] subclass, [23:16] protocol_code,
    // [27:24] endpoint_number, [35:28] endpoint_interval,
    // [51:36] endpoint_max_packet, [52] endpoint_found, [54:53] parse_status,
    // [55] zero
    output logic [55:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import ucdp_pkg::*;

    localparam int CNT_W = $clog2(MAX_BYTES + 1);

    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;
    codes_t     cfg_reg;
    logic       advance;
    step_t      step;
    result_t    res;

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign step.fire = advance;
    assign step.last = in_last_reg;
    assign step.data = in_data_reg;

    ucdp_core #(
        .MAX_BYTES(MAX_BYTES),
        .CNT_W    (CNT_W)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .cfg_codes(cfg_reg),
        .res      (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg       <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance && in_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_DEVICE_CLASS:    cfg_reg.base_class    <= cfg_data;
                    CFG_DEVICE_SUBCLASS: cfg_reg.sub_class     <= cfg_data;
                    CFG_DEVICE_PROTOCOL: cfg_reg.protocol_code <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg};

endmodule

// ----- rtl/ucdp_checker.sv -----
// Port-level checks of the descriptor parser, bound to the top level.
`timescale 1ns / 1ps
`include "usb_config_descriptor_parser_unit_defines.svh"
module ucdp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        cfg_ready
);
    // hold a stalled result
    `UCDP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // status is one of the three defined codes
    `UCDP_ASSERT(a_status_code, m_tvalid |-> m_tdata[54:53] != 2'd3)
    // no endpoint taken means all endpoint fields are zero
    `UCDP_ASSERT(a_ep_zero, m_tvalid && !m_tdata[52] |-> m_tdata[51:24] == 28'd0)
    // configuration writes are never stalled
    `UCDP_ASSERT(a_cfg_ready, cfg_ready)
    // input stalls only behind a result that is held off
    `UCDP_ASSERT(a_in_ready, !m_tvalid || m_tready |-> s_tready)

endmodule

bind usb_config_descriptor_parser_unit ucdp_checker u_ucdp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_ready(cfg_ready)
);
